// ===== rtl/tcm_pkg.sv =====
`default_nettype none
package tcm_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int REG_WIDTH = 15;
    localparam int PROD_WIDTH = 2 * REG_WIDTH;
    localparam int CMP_WIDTH = (COORD_WIDTH > REG_WIDTH) ? COORD_WIDTH : REG_WIDTH;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STAGES = REG_WIDTH;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_PANEL_WIDTH = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TOUCH_MAX_X = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TOUCH_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SWAP_AXES = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIRROR_H = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIRROR_V = 3'd6;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] raw_x;
        logic signed [COORD_WIDTH-1:0] raw_y;
    } t_item;

    typedef struct packed {
        logic [REG_WIDTH-1:0] screen_x;
        logic [REG_WIDTH-1:0] screen_y;
    } t_result;

    typedef struct packed {
        logic [REG_WIDTH-1:0] panel_width;
        logic [REG_WIDTH-1:0] panel_height;
        logic [REG_WIDTH-1:0] touch_max_x;
        logic [REG_WIDTH-1:0] touch_max_y;
        logic                 swap_axes;
        logic                 mirror_horizontal;
        logic                 mirror_vertical;
    } t_cfg;

    typedef struct packed {
        logic                  zero;
        logic [PROD_WIDTH-1:0] prod_x;
        logic [PROD_WIDTH-1:0] prod_y;
        logic [REG_WIDTH-1:0]  div_x;
        logic [REG_WIDTH-1:0]  div_y;
    } t_work;

endpackage
`default_nettype wire

// ===== rtl/tcm_front.sv =====
`default_nettype none
module tcm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tcm_pkg::t_cfg  i_cfg,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire tcm_pkg::t_item i_item,
    output logic                o_work_valid,
    input  wire logic           i_work_ready,
    output tcm_pkg::t_work      o_work
);
    import tcm_pkg::*;

    typedef struct packed {
        logic                 zero;
        logic [REG_WIDTH-1:0] x;
        logic [REG_WIDTH-1:0] y;
        logic [REG_WIDTH-1:0] mx;
        logic [REG_WIDTH-1:0] my;
    } t_map;

    function automatic logic [REG_WIDTH-1:0] clamp_raw(
        input logic signed [COORD_WIDTH-1:0] raw,
        input logic [REG_WIDTH-1:0]          maxv
    );
        logic [CMP_WIDTH-1:0] v;
        logic [CMP_WIDTH-1:0] m;
        logic [REG_WIDTH-1:0] res;
        v = CMP_WIDTH'($unsigned(raw));
        m = CMP_WIDTH'(maxv);
        if (raw[COORD_WIDTH-1]) begin
            res = '0;
        end else if (v > m) begin
            res = maxv;
        end else begin
            res = v[REG_WIDTH-1:0];
        end
        return res;
    endfunction

    logic                 r_v1;
    logic                 r_v2;
    t_map                 r_s1;
    t_map                 n_s1;
    t_work                r_s2;
    t_work                n_s2;
    logic                 adv1;
    logic                 adv2;
    logic [REG_WIDTH-1:0] cx;
    logic [REG_WIDTH-1:0] cy;
    logic [REG_WIDTH-1:0] wm1;
    logic [REG_WIDTH-1:0] hm1;

    assign adv2 = !r_v2 || i_work_ready;
    assign adv1 = !r_v1 || adv2;
    assign o_full = !adv1;
    assign o_work_valid = r_v2;
    assign o_work = r_s2;

    always_comb begin
        cx = clamp_raw(i_item.raw_x, i_cfg.touch_max_x);
        cy = clamp_raw(i_item.raw_y, i_cfg.touch_max_y);
        n_s1.zero = (i_cfg.panel_width == '0) || (i_cfg.panel_height == '0) ||
                    (i_cfg.touch_max_x == '0) || (i_cfg.touch_max_y == '0);
        if (i_cfg.swap_axes) begin
            n_s1.x  = cy;
            n_s1.y  = cx;
            n_s1.mx = i_cfg.touch_max_y;
            n_s1.my = i_cfg.touch_max_x;
        end else begin
            n_s1.x  = cx;
            n_s1.y  = cy;
            n_s1.mx = i_cfg.touch_max_x;
            n_s1.my = i_cfg.touch_max_y;
        end
        if (i_cfg.mirror_horizontal) begin
            n_s1.x = n_s1.mx - n_s1.x;
        end
        if (i_cfg.mirror_vertical) begin
            n_s1.y = n_s1.my - n_s1.y;
        end
    end

    always_comb begin
        wm1 = i_cfg.panel_width - REG_WIDTH'(1);
        hm1 = i_cfg.panel_height - REG_WIDTH'(1);
        n_s2.zero   = r_s1.zero;
        n_s2.prod_x = PROD_WIDTH'(r_s1.x) * PROD_WIDTH'(wm1);
        n_s2.prod_y = PROD_WIDTH'(r_s1.y) * PROD_WIDTH'(hm1);
        n_s2.div_x  = r_s1.mx;
        n_s2.div_y  = r_s1.my;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_push;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= n_s1;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tcm_queue.sv =====
`default_nettype none
module tcm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    output logic                o_full,
    input  wire tcm_pkg::t_work i_data,
    input  wire logic           i_rd,
    output logic                o_empty,
    output tcm_pkg::t_work      o_data
);
    import tcm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_wr;
    logic               do_rd;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (do_rd) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tcm_back.sv =====
`default_nettype none
module tcm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_work_empty,
    output logic                o_work_rd,
    input  wire tcm_pkg::t_work i_work,
    output logic                o_empty,
    input  wire logic           i_pop,
    output tcm_pkg::t_result    o_result
);
    import tcm_pkg::*;

    typedef struct packed {
        logic                 zero;
        logic [REG_WIDTH-1:0] rem_x;
        logic [REG_WIDTH-1:0] low_x;
        logic [REG_WIDTH-1:0] quo_x;
        logic [REG_WIDTH-1:0] div_x;
        logic [REG_WIDTH-1:0] rem_y;
        logic [REG_WIDTH-1:0] low_y;
        logic [REG_WIDTH-1:0] quo_y;
        logic [REG_WIDTH-1:0] div_y;
    } t_div;

    function automatic logic [REG_WIDTH:0] div_step(
        input logic [REG_WIDTH-1:0] rem,
        input logic                 nbit,
        input logic [REG_WIDTH-1:0] dv
    );
        logic [REG_WIDTH:0]   t;
        logic [REG_WIDTH:0]   d;
        logic [REG_WIDTH-1:0] r;
        logic                 q;
        t = {rem, nbit};
        d = {1'b0, dv};
        if (t >= d) begin
            t = t - d;
            q = 1'b1;
        end else begin
            q = 1'b0;
        end
        r = t[REG_WIDTH-1:0];
        return {r, q};
    endfunction

    function automatic t_div step_all(input t_div s, input int k);
        t_div               o;
        logic [REG_WIDTH:0] sx;
        logic [REG_WIDTH:0] sy;
        o  = s;
        sx = div_step(s.rem_x, s.low_x[REG_WIDTH-1-k], s.div_x);
        sy = div_step(s.rem_y, s.low_y[REG_WIDTH-1-k], s.div_y);
        o.rem_x = sx[REG_WIDTH:1];
        o.quo_x = {s.quo_x[REG_WIDTH-2:0], sx[0]};
        o.rem_y = sy[REG_WIDTH:1];
        o.quo_y = {s.quo_y[REG_WIDTH-2:0], sy[0]};
        return o;
    endfunction

    logic    en;
    logic    r_vld [DIV_STAGES];
    t_div    r_st  [DIV_STAGES];
    t_div    n_st0;
    t_div    last;
    logic    r_out_valid;
    t_result r_out;

    assign en        = !r_out_valid || i_pop;
    assign o_work_rd = en && !i_work_empty;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        n_st0.zero  = i_work.zero;
        n_st0.rem_x = i_work.prod_x[PROD_WIDTH-1:REG_WIDTH];
        n_st0.low_x = i_work.prod_x[REG_WIDTH-1:0];
        n_st0.quo_x = '0;
        n_st0.div_x = i_work.div_x;
        n_st0.rem_y = i_work.prod_y[PROD_WIDTH-1:REG_WIDTH];
        n_st0.low_y = i_work.prod_y[REG_WIDTH-1:0];
        n_st0.quo_y = '0;
        n_st0.div_y = i_work.div_y;
        last = step_all(r_st[DIV_STAGES-1], DIV_STAGES - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= !i_work_empty;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_st0;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_st[k] <= step_all(r_st[k-1], k - 1);
            end
            if (last.zero) begin
                r_out.screen_x <= '0;
                r_out.screen_y <= '0;
            end else begin
                r_out.screen_x <= last.quo_x;
                r_out.screen_y <= last.quo_y;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/touch_coordinate_mapper_core.sv =====
// An accepted item passes two front stages, the queue, the 15-stage restoring divider pipeline
// (one quotient bit per stage for each axis) and the output register; its result then shows
// with empty low.
// Throughput: one item per cycle; a result held at the output stalls the divider pipeline.
// Reset (synchronous, active low) empties the pipeline and the queue and clears all
// configuration registers to zero.
`default_nettype none
module touch_coordinate_mapper_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire tcm_pkg::t_item                      i_item,
    output logic                                     empty,
    input  wire logic                                pop,
    output tcm_pkg::t_result                         o_result,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tcm_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [tcm_pkg::REG_WIDTH-1:0]       i_cfg_data
);
    import tcm_pkg::*;

    t_cfg  r_cfg;
    logic  f_valid;
    logic  q_full;
    t_work f_work;
    logic  q_empty;
    logic  q_rd;
    t_work q_work;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PANEL_WIDTH:  r_cfg.panel_width <= i_cfg_data;
                REG_PANEL_HEIGHT: r_cfg.panel_height <= i_cfg_data;
                REG_TOUCH_MAX_X:  r_cfg.touch_max_x <= i_cfg_data;
                REG_TOUCH_MAX_Y:  r_cfg.touch_max_y <= i_cfg_data;
                REG_SWAP_AXES:    r_cfg.swap_axes <= i_cfg_data[0];
                REG_MIRROR_H:     r_cfg.mirror_horizontal <= i_cfg_data[0];
                REG_MIRROR_V:     r_cfg.mirror_vertical <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tcm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .o_full       (full),
        .i_item       (i_item),
        .o_work_valid (f_valid),
        .i_work_ready (!q_full),
        .o_work       (f_work)
    );

    tcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .o_full  (q_full),
        .i_data  (f_work),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_work)
    );

    tcm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_empty (q_empty),
        .o_work_rd    (q_rd),
        .i_work       (q_work),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire
